// ===== rtl/rgbe_rle_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbe_rle_pkg
// Shared types and constants for the RGBE scanline run-length decoder.
// ----------------------------------------------------------------------------
package rgbe_rle_pkg;

    localparam logic [7:0] HDR_BYTE  = 8'd2;
    localparam logic [1:0] EXP_PLANE = 2'd3;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_WHI  = 3'd2,
        PH_WLO  = 3'd3,
        PH_CODE = 3'd4,
        PH_LIT  = 3'd5,
        PH_RUNV = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HEADER = 2'd1,
        ST_OVERRUN    = 2'd2
    } status_t;

    // one descriptor as the front hands it to the back
    typedef struct packed {
        logic [1:0]  channel;
        logic [15:0] start_column;
        logic [6:0]  run_count;
        logic [7:0]  fill_value;
        logic        line_done;
        status_t     status;
        logic        eol;        // scanline finished or abandoned: bump row
    } cmd_t;

endpackage

// ===== rtl/rgbe_byte_if.sv =====
// ----------------------------------------------------------------------------
// rgbe_byte_if
// Valid/ready channel carrying one encoded stream byte per beat.
// ----------------------------------------------------------------------------
interface rgbe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

// ===== rtl/rgbe_desc_if.sv =====
// ----------------------------------------------------------------------------
// rgbe_desc_if
// Valid/ready channel carrying one fill descriptor per beat.
// ----------------------------------------------------------------------------
interface rgbe_desc_if;
    logic        valid;
    logic        ready;
    logic [1:0]  channel;
    logic [15:0] start_column;
    logic [6:0]  run_count;
    logic [7:0]  fill_value;
    logic [15:0] row_index;
    logic        line_done;
    logic [1:0]  status;

    modport source (output valid, output channel, output start_column, output run_count,
                    output fill_value, output row_index, output line_done, output status,
                    input ready);
    modport sink   (input valid, input channel, input start_column, input run_count,
                    input fill_value, input row_index, input line_done, input status,
                    output ready);
endinterface

// ===== rtl/rgbe_rle_front.sv =====
// ----------------------------------------------------------------------------
// rgbe_rle_front
// Byte parser: header, width, codes, literal and run bytes; builds commands.
// ----------------------------------------------------------------------------
module rgbe_rle_front
    import rgbe_rle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rgbe_byte_if.sink   stream,
    input  logic        cmd_ready,
    output logic        cmd_valid,
    output cmd_t        cmd
);

    phase_t      phase_reg,    phase_next;
    logic [15:0] width_reg,    width_next;
    logic [1:0]  plane_reg,    plane_next;
    logic [15:0] column_reg,   column_next;
    logic [6:0]  lit_left_reg, lit_left_next;
    logic [6:0]  rep_len_reg,  rep_len_next;
    logic        clip_reg,     clip_next;

    logic        fire;
    logic [7:0]  b;
    logic [15:0] room;
    logic [6:0]  code_len;
    logic        code_over;
    logic [6:0]  lit_dec;
    logic [6:0]  fill_cnt;
    logic [16:0] next_col;
    logic        reach_end;
    logic        last_plane;
    logic        end_now;

    assign stream.ready = cmd_ready;
    assign fire         = stream.valid && cmd_ready;
    assign b            = stream.stream_byte;

    assign room       = width_reg - column_reg;
    assign code_len   = b[6:0];
    assign code_over  = {9'd0, code_len} > room;
    assign lit_dec    = lit_left_reg - 7'd1;
    assign fill_cnt   = (phase_reg == PH_RUNV) ? rep_len_reg : 7'd1;
    assign next_col   = {1'b0, column_reg} + {10'd0, fill_cnt};
    assign reach_end  = next_col >= {1'b0, width_reg};
    assign last_plane = plane_reg == EXP_PLANE;

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        width_next    = width_reg;
        plane_next    = plane_reg;
        column_next   = column_reg;
        lit_left_next = lit_left_reg;
        rep_len_next  = rep_len_reg;
        clip_next     = clip_reg;
        end_now       = 1'b0;
        if (fire)
        begin
            unique case (phase_reg)
                PH_HDR0, PH_HDR1:
                begin
                    if (b != HDR_BYTE)
                        phase_next = PH_HDR0;
                    else
                        phase_next = (phase_reg == PH_HDR0) ? PH_HDR1 : PH_WHI;
                end
                PH_WHI:
                begin
                    width_next = {b, 8'h00};
                    phase_next = PH_WLO;
                end
                PH_WLO:
                begin
                    width_next  = {width_reg[15:8], b};
                    plane_next  = 2'd0;
                    column_next = 16'd0;
                    clip_next   = 1'b0;
                    if ({width_reg[15:8], b} == 16'd0)
                        end_now = 1'b1;
                    else
                        phase_next = PH_CODE;
                end
                PH_CODE:
                begin
                    if (!b[7])
                    begin
                        if (code_len != 7'd0)
                        begin
                            lit_left_next = code_over ? room[6:0] : code_len;
                            clip_next     = code_over;
                            phase_next    = PH_LIT;
                        end
                    end
                    else
                    begin
                        rep_len_next = code_over ? room[6:0] : code_len;
                        clip_next    = code_over;
                        phase_next   = PH_RUNV;
                    end
                end
                PH_LIT, PH_RUNV:
                begin
                    if (phase_reg == PH_LIT)
                        lit_left_next = lit_dec;
                    else
                        rep_len_next = 7'd0;
                    if (phase_reg == PH_LIT && lit_dec != 7'd0)
                        column_next = column_reg + 16'd1;
                    else if (phase_reg == PH_RUNV && rep_len_reg == 7'd0)
                        phase_next = PH_CODE;
                    else if (clip_reg)
                        end_now = 1'b1;
                    else if (reach_end)
                    begin
                        if (last_plane)
                            end_now = 1'b1;
                        else
                        begin
                            plane_next  = plane_reg + 2'd1;
                            column_next = 16'd0;
                            phase_next  = PH_CODE;
                        end
                    end
                    else
                    begin
                        column_next = next_col[15:0];
                        phase_next  = PH_CODE;
                    end
                end
                default:
                    phase_next = PH_HDR0;
            endcase
            if (end_now)
            begin
                plane_next    = 2'd0;
                column_next   = 16'd0;
                lit_left_next = 7'd0;
                rep_len_next  = 7'd0;
                clip_next     = 1'b0;
                phase_next    = PH_HDR0;
            end
        end
    end

    // command output
    always_comb
    begin
        cmd_valid        = 1'b0;
        cmd.channel      = plane_reg;
        cmd.start_column = column_reg;
        cmd.run_count    = fill_cnt;
        cmd.fill_value   = b;
        cmd.line_done    = 1'b0;
        cmd.status       = ST_OK;
        cmd.eol          = 1'b0;
        unique case (phase_reg)
            PH_HDR0, PH_HDR1:
            begin
                cmd_valid        = fire && (b != HDR_BYTE);
                cmd.channel      = 2'd0;
                cmd.start_column = 16'd0;
                cmd.run_count    = 7'd0;
                cmd.status       = ST_BAD_HEADER;
            end
            PH_WLO:
            begin
                // empty scanline: one closing descriptor
                cmd_valid        = fire && ({width_reg[15:8], b} == 16'd0);
                cmd.channel      = EXP_PLANE;
                cmd.start_column = 16'd0;
                cmd.run_count    = 7'd0;
                cmd.fill_value   = 8'd0;
                cmd.line_done    = 1'b1;
                cmd.eol          = 1'b1;
            end
            PH_LIT, PH_RUNV:
            begin
                if (phase_reg == PH_LIT)
                    cmd_valid = fire;
                else
                    cmd_valid = fire && (rep_len_reg != 7'd0);
                // ends a literal or a run: may close the plane
                if (phase_reg == PH_RUNV || lit_dec == 7'd0)
                begin
                    if (clip_reg)
                    begin
                        cmd.status = ST_OVERRUN;
                        cmd.eol    = 1'b1;
                    end
                    else
                    begin
                        cmd.line_done = reach_end && last_plane;
                        cmd.eol       = reach_end && last_plane;
                    end
                end
            end
            default:
                cmd_valid = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR0;
            width_reg    <= 16'd0;
            plane_reg    <= 2'd0;
            column_reg   <= 16'd0;
            lit_left_reg <= 7'd0;
            rep_len_reg  <= 7'd0;
            clip_reg     <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            width_reg    <= width_next;
            plane_reg    <= plane_next;
            column_reg   <= column_next;
            lit_left_reg <= lit_left_next;
            rep_len_reg  <= rep_len_next;
            clip_reg     <= clip_next;
        end
    end

    // inside a scanline the position never reaches the width
    a_column_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CODE || phase_reg == PH_LIT || phase_reg == PH_RUNV)
        |-> (column_reg < width_reg))
        else $error("column ran past line width");

    // header errors never fill columns or close a line
    a_bad_header_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd.status == ST_BAD_HEADER)
        |-> (cmd.run_count == 7'd0 && !cmd.eol && !cmd.line_done))
        else $error("bad header descriptor carries a fill");

endmodule

// ===== rtl/rgbe_rle_queue.sv =====
// ----------------------------------------------------------------------------
// rgbe_rle_queue
// Short command queue decoupling the parser from the output stage.
// ----------------------------------------------------------------------------
module rgbe_rle_queue
    import rgbe_rle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  cmd_t push_cmd,
    output logic push_ready,
    output logic pop_valid,
    output cmd_t pop_cmd,
    input  logic pop_ready
);

    cmd_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg,  count_next;
    logic                   push;
    logic                   pop;

    assign push_ready = count_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QUEUE_PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QUEUE_PTR_W'(1);
        count_next = count_reg + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("command queue overfilled");

endmodule

// ===== rtl/rgbe_rle_back.sv =====
// ----------------------------------------------------------------------------
// rgbe_rle_back
// Output stage: stamps the row number and holds the descriptor for the sink.
// ----------------------------------------------------------------------------
module rgbe_rle_back
    import rgbe_rle_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  cmd_t          cmd,
    output logic          cmd_ready,
    rgbe_desc_if.source   descriptor
);

    logic        out_valid_reg,  out_valid_next;
    cmd_t        out_cmd_reg;
    logic [15:0] out_row_reg;
    logic [15:0] row_count_reg,  row_count_next;
    logic        take;

    assign cmd_ready = !out_valid_reg || descriptor.ready;
    assign take      = cmd_valid && cmd_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        row_count_next = row_count_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            if (cmd.eol)
                row_count_next = row_count_reg + 16'd1;
        end
        else if (descriptor.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_cmd_reg <= cmd;
            out_row_reg <= row_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            row_count_reg <= 16'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            row_count_reg <= row_count_next;
        end
    end

    assign descriptor.valid        = out_valid_reg;
    assign descriptor.channel      = out_cmd_reg.channel;
    assign descriptor.start_column = out_cmd_reg.start_column;
    assign descriptor.run_count    = out_cmd_reg.run_count;
    assign descriptor.fill_value   = out_cmd_reg.fill_value;
    assign descriptor.row_index    = out_row_reg;
    assign descriptor.line_done    = out_cmd_reg.line_done;
    assign descriptor.status       = out_cmd_reg.status;

    // the row number only moves when a line-closing command is taken
    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        (row_count_reg != $past(row_count_reg)) |-> $past(take && cmd.eol))
        else $error("row counter moved without a line end");

endmodule

// ===== rtl/rgbe_scanline_rle_decoder.sv =====
// ----------------------------------------------------------------------------
// rgbe_scanline_rle_decoder
// Adaptive RLE decoder for RGBE scanline pixel data, one byte per beat.
// ----------------------------------------------------------------------------
// Throughput: one stream byte per cycle, sustained, with the sink ready.
// After its byte is accepted, a descriptor is written into the queue and then into
//   the output register.
// Bytes that only advance the parser (good header bytes, a nonzero width, codes) give no beat.
// Reset (rst_n low, async): parser waits for the first header byte, row
//   counter is zero, command queue and output register are empty.
// ----------------------------------------------------------------------------
module rgbe_scanline_rle_decoder
    import rgbe_rle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rgbe_byte_if.sink   stream,
    rgbe_desc_if.source descriptor
);

    // Front: owns the whole parse state (phase, width, plane, column,
    // literal/run counts, clip flag) and emits at most one command per byte.
    // Clipping needs the live column, so plane/column tracking stays here.
    logic front_valid;
    cmd_t front_cmd;
    logic front_ready;

    // Back: stamps the row number and advances it on every line end,
    // including an abandoned (overrun) line.
    logic back_valid;
    cmd_t back_cmd;
    logic back_ready;

    rgbe_rle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream),
        .cmd_ready (front_ready),
        .cmd_valid (front_valid),
        .cmd       (front_cmd)
    );

    // Two-entry queue: the parser keeps taking bytes while a finished
    // descriptor waits at the output.
    rgbe_rle_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_cmd   (front_cmd),
        .push_ready (front_ready),
        .pop_valid  (back_valid),
        .pop_cmd    (back_cmd),
        .pop_ready  (back_ready)
    );

    rgbe_rle_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (back_valid),
        .cmd        (back_cmd),
        .cmd_ready  (back_ready),
        .descriptor (descriptor)
    );

endmodule
